// File: sv/ifke_pkg.sv
// Shared types, codes and helpers for the IPv4 flow key extractor.
package ifke_pkg;

    localparam int unsigned POS_W = 7;    // frame byte count, saturates at 127
    localparam int unsigned ETH_HDR_BYTES = 14;
    localparam int unsigned AF_GLUE_DEFAULT = 1;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  AF_INET = 8'd2;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;
    localparam logic [5:0]  IP_MIN_HDR = 6'd20;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [4:0] TCP_MIN_BYTES  = 5'd20;
    localparam logic [4:0] UDP_MIN_BYTES  = 5'd8;
    localparam logic [4:0] ICMP_MIN_BYTES = 5'd8;

    typedef enum logic [1:0] {
        LT_ETH  = 2'd0,
        LT_RAW  = 2'd1,
        LT_GLUE = 2'd2,
        LT_NONE = 2'd3
    } link_t;

    typedef enum logic [0:0] {
        CFG_LINK_TYPE = 1'b0,
        CFG_VERBOSE   = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_BAD_HLEN  = 3'd4,
        ST_TRUNC     = 3'd5
    } status_t;

    // Header fields of one complete frame, handed from capture to check
    typedef struct packed {
        logic [POS_W-1:0] n_bytes;
        logic [15:0]      link_word;
        logic [7:0]       ver_ihl;
        logic [15:0]      length;
        logic [12:0]      frag_off;
        logic [7:0]       protocol;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic [31:0]      transport;
    } frame_sum_t;

    typedef struct packed {
        logic [39:0] bytes_total;
        logic [31:0] packets_total;
        logic [15:0] ip_length;
        logic [31:0] ports_word;
        logic [7:0]  protocol;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        status_t     status;
    } result_t;

    function automatic logic [POS_W-1:0] link_len(input link_t lt, input int unsigned glue);
        logic [POS_W-1:0] len;
        len = '0;
        case (lt)
            LT_ETH:  len = POS_W'(ETH_HDR_BYTES);
            LT_GLUE: len = POS_W'(glue);
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

// File: sv/ifke_capture.sv
// Per-byte header capture; hands a frame summary on at the last byte.
module ifke_capture
    import ifke_pkg::*;
#(
    parameter int unsigned AF_GLUE_BYTES = AF_GLUE_DEFAULT
)(
    input  logic       clk,
    input  logic       rst_n,
    input  link_t      link_type,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       sum_valid,
    input  logic       sum_ready,
    output frame_sum_t sum
);

    logic [POS_W-1:0] pos_reg, pos_next, pos_inc;
    logic [15:0]      link_word_reg, link_word_next;
    logic [7:0]       ver_ihl_reg, ver_ihl_next;
    logic [15:0]      length_reg, length_next;
    logic [12:0]      frag_reg, frag_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [31:0]      tw_reg, tw_next;
    logic             sum_valid_reg, sum_valid_next;
    frame_sum_t       sum_reg, sum_next;

    logic [POS_W-1:0] hdr_len;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] ihl_bytes;
    logic             accept;

    assign in_ready  = !sum_valid_reg || sum_ready;
    assign accept    = in_valid && in_ready;
    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

    assign hdr_len   = link_len(link_type, AF_GLUE_BYTES);
    assign off       = pos_reg - hdr_len;
    assign ihl_bytes = {1'b0, ver_ihl_reg[3:0], 2'b00};
    assign pos_inc   = (pos_reg == {POS_W{1'b1}}) ? pos_reg : pos_reg + POS_W'(1);

    always_comb
    begin
        link_word_next = link_word_reg;
        ver_ihl_next   = ver_ihl_reg;
        length_next    = length_reg;
        frag_next      = frag_reg;
        proto_next     = proto_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        tw_next        = tw_reg;

        if (link_type == LT_ETH && (pos_reg == POS_W'(12) || pos_reg == POS_W'(13)))
        begin
            link_word_next = {link_word_reg[7:0], data_byte};
        end
        if (link_type == LT_GLUE && pos_reg < hdr_len)
        begin
            // leading glue bytes must be zero; a nonzero one sticks in bit 15
            if (pos_reg + POS_W'(1) == hdr_len)
            begin
                link_word_next = {link_word_reg[15], 7'd0, data_byte};
            end
            else if (data_byte != 8'd0)
            begin
                link_word_next[15] = 1'b1;
            end
        end
        if (link_type != LT_NONE && pos_reg >= hdr_len)
        begin
            case (off)
                POS_W'(0):  ver_ihl_next = data_byte;
                POS_W'(2),
                POS_W'(3):  length_next = {length_reg[7:0], data_byte};
                POS_W'(6),
                POS_W'(7):  frag_next = {frag_reg[4:0], data_byte};
                POS_W'(9):  proto_next = data_byte;
                POS_W'(12),
                POS_W'(13),
                POS_W'(14),
                POS_W'(15): src_next = {src_reg[23:0], data_byte};
                POS_W'(16),
                POS_W'(17),
                POS_W'(18),
                POS_W'(19): dst_next = {dst_reg[23:0], data_byte};
                default:    ;
            endcase
            if (ihl_bytes >= POS_W'(IP_MIN_HDR) && off >= ihl_bytes
                && (off - ihl_bytes) < POS_W'(4))
            begin
                tw_next = {tw_reg[23:0], data_byte};
            end
        end
    end

    always_comb
    begin
        sum_next.n_bytes   = pos_inc;
        sum_next.link_word = link_word_next;
        sum_next.ver_ihl   = ver_ihl_next;
        sum_next.length    = length_next;
        sum_next.frag_off  = frag_next;
        sum_next.protocol  = proto_next;
        sum_next.src       = src_next;
        sum_next.dst       = dst_next;
        sum_next.transport = tw_next;

        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = last_byte ? '0 : pos_inc;
        end

        sum_valid_next = sum_valid_reg;
        if (accept && last_byte)
        begin
            sum_valid_next = 1'b1;
        end
        else if (sum_ready)
        begin
            sum_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            link_word_reg <= '0;
            ver_ihl_reg   <= '0;
            length_reg    <= '0;
            frag_reg      <= '0;
            proto_reg     <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            tw_reg        <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_valid_reg <= sum_valid_next;
            if (accept)
            begin
                if (last_byte)
                begin
                    link_word_reg <= '0;
                    ver_ihl_reg   <= '0;
                    length_reg    <= '0;
                    frag_reg      <= '0;
                    proto_reg     <= '0;
                    src_reg       <= '0;
                    dst_reg       <= '0;
                    tw_reg        <= '0;
                end
                else
                begin
                    link_word_reg <= link_word_next;
                    ver_ihl_reg   <= ver_ihl_next;
                    length_reg    <= length_next;
                    frag_reg      <= frag_next;
                    proto_reg     <= proto_next;
                    src_reg       <= src_next;
                    dst_reg       <= dst_next;
                    tw_reg        <= tw_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

// File: sv/ifke_check.sv
// Frame checks, running totals and the result register.
module ifke_check
    import ifke_pkg::*;
#(
    parameter int unsigned AF_GLUE_BYTES = AF_GLUE_DEFAULT
)(
    input  logic       clk,
    input  logic       rst_n,
    input  link_t      link_type,
    input  logic       verbose_mode,
    input  logic       sum_valid,
    output logic       sum_ready,
    input  frame_sum_t sum,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    result
);

    logic [31:0] packets_reg, packets_next;
    logic [39:0] bytes_reg, bytes_next;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;

    logic [POS_W-1:0] hdr_len;
    logic [POS_W-1:0] ihl_bytes;
    logic [POS_W-1:0] need_lim;
    logic [4:0]       need;
    status_t          st;
    logic [31:0]      ports;
    logic [7:0]       proto;
    logic             take;

    assign sum_ready = !out_valid_reg || out_ready;
    assign take      = sum_valid && sum_ready;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign hdr_len   = link_len(link_type, AF_GLUE_BYTES);
    assign ihl_bytes = {1'b0, sum.ver_ihl[3:0], 2'b00};
    assign need_lim  = hdr_len + ihl_bytes + POS_W'(need);

    always_comb
    begin
        need = 5'd0;
        case (sum.protocol)
            PROTO_TCP:  need = TCP_MIN_BYTES;
            PROTO_UDP:  need = UDP_MIN_BYTES;
            PROTO_ICMP: need = ICMP_MIN_BYTES;
            default:    need = 5'd0;
        endcase
    end

    always_comb
    begin
        st    = ST_OK;
        ports = '0;
        proto = '0;
        if (link_type == LT_NONE)
        begin
            st = ST_NOT_IPV4;
        end
        else if (sum.n_bytes < hdr_len)
        begin
            st = ST_SHORT;
        end
        else if (link_type == LT_ETH && sum.link_word != ETHERTYPE_IPV4)
        begin
            st = ST_NOT_IPV4;
        end
        else if (link_type == LT_GLUE && sum.link_word != {8'd0, AF_INET})
        begin
            st = ST_NOT_IPV4;
        end
        else if (sum.n_bytes < hdr_len + POS_W'(IP_MIN_HDR))
        begin
            st = ST_SHORT;
        end
        else if (sum.ver_ihl[7:4] != IP_VERSION_4)
        begin
            st = ST_BAD_VER;
        end
        else if (ihl_bytes < POS_W'(IP_MIN_HDR))
        begin
            st = ST_BAD_HLEN;
        end
        else if (verbose_mode)
        begin
            proto = sum.protocol;
            // later fragments carry no transport header
            if (sum.frag_off == '0)
            begin
                if (need != 5'd0 && sum.n_bytes < need_lim)
                begin
                    st = ST_TRUNC;
                end
                else if (sum.protocol == PROTO_TCP || sum.protocol == PROTO_UDP)
                begin
                    ports = sum.transport;
                end
                else if (sum.protocol == PROTO_ICMP)
                begin
                    ports = {sum.transport[23:16], 8'd0, sum.transport[31:24], 8'd0};
                end
            end
        end
    end

    always_comb
    begin
        packets_next = packets_reg;
        bytes_next   = bytes_reg;
        if (take && st == ST_OK)
        begin
            packets_next = packets_reg + 32'd1;
            bytes_next   = bytes_reg + {24'd0, sum.length};
        end

        result_next.status        = st;
        result_next.src_addr      = (st == ST_OK) ? sum.src : '0;
        result_next.dst_addr      = (st == ST_OK) ? sum.dst : '0;
        result_next.protocol      = (st == ST_OK) ? proto : '0;
        result_next.ports_word    = (st == ST_OK) ? ports : '0;
        result_next.ip_length     = (st == ST_OK) ? sum.length : '0;
        result_next.packets_total = packets_next;
        result_next.bytes_total   = bytes_next;

        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packets_reg   <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            packets_reg   <= packets_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: sv/ip_flow_key_extractor.sv
// Top level of the IPv4 flow key extractor.
//
//  channel   dir  width  contents
//  s_axis    in   8+1    frame byte in tdata, tlast on the final byte
//  m_axis    out  200    one result word per frame
//  cfg       in   1+2    register write: index, data
//
// One byte is taken per cycle unless the input is stalled. Bytes update the
// header capture registers as they arrive; the last byte moves the frame summary
// into the summary register, and the check stage registers the result word once
// the result register is free. A stalled result holds the check stage; bytes flow
// until a frame end fills the summary register, and stop while it stays full.
// Reset clears the configuration, the frame capture and the running totals.
module ip_flow_key_extractor
    import ifke_pkg::*;
#(
    parameter int unsigned AF_GLUE_BYTES = AF_GLUE_DEFAULT
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [34:3] src_addr, [66:35] dst_addr, [74:67] protocol,
    // [106:75] ports_word, [122:107] ip_length, [154:123] packets_total,
    // [194:155] bytes_total, [199:195] zero
    output logic [199:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [1:0]   cfg_data
);

    link_t      link_type_reg;
    logic       verbose_reg;
    logic       sum_valid;
    logic       sum_ready;
    frame_sum_t sum;
    result_t    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_type_reg <= LT_ETH;
            verbose_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINK_TYPE: link_type_reg <= link_t'(cfg_data);
                CFG_VERBOSE:   verbose_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    ifke_capture #(
        .AF_GLUE_BYTES (AF_GLUE_BYTES)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_type (link_type_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum)
    );

    ifke_check #(
        .AF_GLUE_BYTES (AF_GLUE_BYTES)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .link_type    (link_type_reg),
        .verbose_mode (verbose_reg),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum          (sum),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .result       (result)
    );

    assign m_axis_tdata = {5'd0, result};

    // input only stalls while a finished frame waits for the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> sum_valid && !sum_ready)
        else $error("input stalled without a pending frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && result.status != ST_OK |->
            result.src_addr == '0 && result.dst_addr == '0 && result.ports_word == '0)
        else $error("error result carries header fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && result.protocol != '0 |-> verbose_reg)
        else $error("protocol given outside verbose mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && sum_ready && $past(m_axis_tvalid && m_axis_tready && sum_valid
            && sum_ready && result.status == ST_OK)
        |=> m_axis_tvalid)
        else $error("result lost after back-to-back frames");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && result.status == ST_OK
        |=> result.packets_total == $past(result.packets_total) + 32'd1 || !m_axis_tvalid
            || $past(result.packets_total) == result.packets_total - 32'd1
            || result.status != ST_OK || $stable(result.packets_total) == 1'b0)
        else $error("packet total out of step");

endmodule
